FILE: rtl/handle_table_free_slot_reuse_unit_defines.svh
// ---------------------------------------------------------------------------
// handle table assertion macros
// shared concurrent assertion forms for the handle table rtl
// ---------------------------------------------------------------------------
`ifndef HANDLE_TABLE_FREE_SLOT_REUSE_UNIT_DEFINES_SVH
`define HANDLE_TABLE_FREE_SLOT_REUSE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HTFSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HTFSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/htfsr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htfsr_pkg
// command and status codes and default sizes of the handle table
// ---------------------------------------------------------------------------
package htfsr_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

endpackage

FILE: rtl/htfsr_free_fifo.sv
`timescale 1ns / 1ps
`include "handle_table_free_slot_reuse_unit_defines.svh"
// ---------------------------------------------------------------------------
// htfsr_free_fifo
// fifo of freed slot indices with the head entry prefetched into a register
// ---------------------------------------------------------------------------
module htfsr_free_fifo
    import htfsr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int SLOT_W  = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [SLOT_W-1:0] push_slot,
    input  logic              pop,
    output logic [SLOT_W-1:0] head_slot,
    output logic [CNT_W-1:0]  count
);

    localparam logic [SLOT_W-1:0] LAST_PTR = SLOT_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(CAPACITY);

    logic [SLOT_W-1:0] mem [CAPACITY];
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] qhead_reg;

    always_comb begin
        head_next = head_reg;
        if (pop) begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + SLOT_W'(1);
        end
        tail_next = tail_reg;
        if (push) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + SLOT_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // keep the head entry in a register; a push to a queue left empty bypasses
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_slot;
        end
        if (push && (tail_reg == head_next)) begin
            qhead_reg <= push_slot;
        end else begin
            qhead_reg <= mem[head_next];
        end
    end

    assign head_slot = qhead_reg;
    assign count     = count_reg;

    `HTFSR_ASSERT_IMPLY(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0,
                        "pop from empty free queue")
    `HTFSR_ASSERT_IMPLY(a_push_notfull, aclk, aresetn, push, count_reg != FULL_CNT,
                        "push into full free queue")
    `HTFSR_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT,
                        "free count above capacity")

endmodule

FILE: rtl/htfsr_entry_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htfsr_entry_mem
// value store of the handle table, one write and one registered read port
// ---------------------------------------------------------------------------
module htfsr_entry_mem
    import htfsr_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int SLOT_W     = $clog2(CAPACITY)
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [SLOT_W-1:0]      wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [SLOT_W-1:0]      rd_addr,
    output logic [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/handle_table_free_slot_reuse_unit.sv
`timescale 1ns / 1ps
`include "handle_table_free_slot_reuse_unit_defines.svh"
// ---------------------------------------------------------------------------
// handle_table_free_slot_reuse_unit
// handle table with fifo reuse of freed slots
// ---------------------------------------------------------------------------
// One command is taken per clock (add, remove or read) unless held
// results back up the pipeline, and each gives one result: the table
// state (occupied bits, high-water mark, free queue pointers) is updated
// at the input transfer while the value store read is registered, and
// the result is formed from that read in an output register. An add reuses
// the oldest freed slot, else takes the next slot at the high-water mark,
// else reports full. Removing or reading a slot at or beyond the high-water
// mark, or removing a slot that is already free, reports a bad slot and
// changes nothing. The value store and the free queue are memories that
// need no clearing after reset; occupied bits are cleared by reset.
// ---------------------------------------------------------------------------
module handle_table_free_slot_reuse_unit
    import htfsr_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int SLOT_W     = $clog2(CAPACITY),
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int S_DATA_W   = ((CMD_W + SLOT_W + VALUE_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W   = ((SLOT_W + VALUE_WIDTH + ST_W + 2 * CNT_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cmd, slot_index, entry_value
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // given_slot, read_value, status, table_size, live_count
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [CMD_W-1:0]       in_cmd;
    logic [SLOT_W-1:0]      in_idx;
    logic [VALUE_WIDTH-1:0] in_val;
    logic                   accept;

    logic [CAPACITY-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]       hw_reg, hw_next;

    logic                   fifo_push, fifo_pop;
    logic [SLOT_W-1:0]      fifo_head;
    logic [CNT_W-1:0]       fifo_count;
    logic [CNT_W-1:0]       free_next;

    logic                   in_range, idx_occ;
    logic                   add_ok, rd_en;
    logic [SLOT_W-1:0]      add_slot;
    logic [ST_W-1:0]        res_status;
    logic                   res_hit;
    logic [VALUE_WIDTH-1:0] rd_data;

    logic                   st1_vld_reg;
    logic [SLOT_W-1:0]      st1_given_reg;
    logic [ST_W-1:0]        st1_status_reg;
    logic [CNT_W-1:0]       st1_size_reg;
    logic [CNT_W-1:0]       st1_live_reg;
    logic                   st1_hit_reg;
    logic                   st1_adv;

    logic                   out_vld_reg;
    logic [M_DATA_W-1:0]    out_data_reg;
    logic [VALUE_WIDTH-1:0] st1_value;

    assign in_cmd = s_tdata[CMD_W-1:0];
    assign in_idx = s_tdata[CMD_W +: SLOT_W];
    assign in_val = s_tdata[CMD_W + SLOT_W +: VALUE_WIDTH];

    assign st1_adv  = st1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !st1_vld_reg || !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // hw never exceeds capacity, so the range check also guards the occupied lookup
    assign in_range = CNT_W'(in_idx) < hw_reg;
    assign idx_occ  = in_range && occ_reg[in_idx];

    always_comb begin
        occ_next   = occ_reg;
        hw_next    = hw_reg;
        fifo_push  = 1'b0;
        fifo_pop   = 1'b0;
        add_ok     = 1'b0;
        add_slot   = '0;
        rd_en      = 1'b0;
        res_status = ST_OK;
        res_hit    = 1'b0;
        if (accept) begin
            case (in_cmd)
                CMD_ADD: begin
                    if (fifo_count != '0) begin
                        add_ok   = 1'b1;
                        add_slot = fifo_head;
                        fifo_pop = 1'b1;
                    end else if (hw_reg != FULL_CNT) begin
                        add_ok   = 1'b1;
                        add_slot = hw_reg[SLOT_W-1:0];
                        hw_next  = hw_reg + CNT_W'(1);
                    end else begin
                        res_status = ST_FULL;
                    end
                    if (add_ok) begin
                        occ_next[add_slot] = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (idx_occ) begin
                        occ_next[in_idx] = 1'b0;
                        fifo_push        = 1'b1;
                    end else begin
                        res_status = ST_BAD;
                    end
                end
                CMD_READ: begin
                    rd_en = 1'b1;
                    if (!in_range) begin
                        res_status = ST_BAD;
                    end
                    res_hit = idx_occ;
                end
                default: begin
                end
            endcase
        end
    end

    assign free_next = fifo_count + CNT_W'(fifo_push) - CNT_W'(fifo_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            hw_reg  <= '0;
        end else begin
            occ_reg <= occ_next;
            hw_reg  <= hw_next;
        end
    end

    htfsr_free_fifo #(
        .CAPACITY (CAPACITY)
    ) u_free_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_slot (in_idx),
        .pop       (fifo_pop),
        .head_slot (fifo_head),
        .count     (fifo_count)
    );

    htfsr_entry_mem #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_entry_mem (
        .aclk    (aclk),
        .wr_en   (add_ok),
        .wr_addr (add_slot),
        .wr_data (in_val),
        .rd_en   (rd_en),
        .rd_addr (in_idx),
        .rd_data (rd_data)
    );

    // result stage 1: control fields, value comes from the registered store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
        end else if (accept) begin
            st1_vld_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_given_reg  <= add_slot;
            st1_status_reg <= res_status;
            st1_size_reg   <= hw_next;
            st1_live_reg   <= hw_next - free_next;
            st1_hit_reg    <= res_hit;
        end
    end

    assign st1_value = st1_hit_reg ? rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (st1_adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            out_data_reg <= M_DATA_W'({st1_live_reg, st1_size_reg, st1_status_reg,
                                       st1_value, st1_given_reg});
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    `HTFSR_ASSERT_IMPLY(a_live_matches_occ, aclk, aresetn, 1'b1,
                        (CNT_W'($countones(occ_reg)) + fifo_count) == hw_reg,
                        "occupied bits disagree with live count")

endmodule

FILE: verif/handle_table_free_slot_reuse_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// handle_table_free_slot_reuse_unit_tb
// self-checking bench for the handle table with fifo slot reuse
// ---------------------------------------------------------------------------
// A queue of commands feeds a clocked stream driver. Each accepted command
// runs through a local table model that predicts the reply. A clocked
// monitor checks every reply against the oldest prediction. Commands start
// with a short directed list of corner cases. Then come a full-table fill
// and a sweep that frees every slot, followed by random chunks of adds,
// removes, reads and noise. Both sides insert random gaps, and the reply
// side holds off once for a long stretch so that the block backs up.
// ---------------------------------------------------------------------------
module handle_table_free_slot_reuse_unit_tb;
    import htfsr_pkg::*;

    localparam int CAP        = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int VAL_W      = 32;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 56;
    localparam int NUM_ITEMS  = 700;
    localparam int HOLD_CYC   = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot_index;
        logic [VAL_W-1:0]  entry_value;
    } table_cmd_t;

    typedef struct {
        logic [SLOT_W-1:0] given_slot;
        logic [VAL_W-1:0]  read_value;
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  table_size;
        logic [CNT_W-1:0]  live_count;
    } table_reply_t;

    typedef enum int {CHUNK_MIXED, CHUNK_FILL, CHUNK_DRAIN, CHUNK_READS, CHUNK_NOISE} chunk_kind_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // model of the table
    logic [VAL_W-1:0]  slot_value [CAP];
    logic              slot_busy  [CAP];
    logic [SLOT_W-1:0] recycle_fifo [CAP];
    logic [SLOT_W-1:0] recycle_rd;
    logic [SLOT_W-1:0] recycle_wr;
    logic [CNT_W-1:0]  recycle_cnt;
    logic [CNT_W-1:0]  watermark;

    table_cmd_t   cmd_backlog [$];
    table_reply_t replies_due [$];

    int  cmds_accepted = 0;
    int  cmds_queued   = 0;
    int  fail_cnt      = 0;
    int  cycle_cnt     = 0;
    int  tx_gap        = 0;
    int  rx_stall      = 0;
    bit  tx_no_gaps    = 1'b0;
    bit  rx_no_stall   = 1'b0;
    logic rx_hold      = 1'b0;

    handle_table_free_slot_reuse_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // apply one command to the model and return the reply it should give
    function automatic table_reply_t table_apply(table_cmd_t c);
        table_reply_t r;
        logic [SLOT_W-1:0] slot;
        r.given_slot = '0;
        r.read_value = '0;
        r.status     = ST_OK;
        case (c.cmd)
            CMD_ADD: begin
                if (recycle_cnt != 0) begin
                    slot = recycle_fifo[recycle_rd];
                    recycle_rd  = recycle_rd + SLOT_W'(1);
                    recycle_cnt = recycle_cnt - CNT_W'(1);
                    slot_value[slot] = c.entry_value;
                    slot_busy[slot]  = 1'b1;
                    r.given_slot     = slot;
                end else if (watermark < CAP) begin
                    slot = watermark[SLOT_W-1:0];
                    watermark = watermark + CNT_W'(1);
                    slot_value[slot] = c.entry_value;
                    slot_busy[slot]  = 1'b1;
                    r.given_slot     = slot;
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if ({1'b0, c.slot_index} >= watermark || !slot_busy[c.slot_index]) begin
                    r.status = ST_BAD;
                end else begin
                    slot_busy[c.slot_index] = 1'b0;
                    recycle_fifo[recycle_wr] = c.slot_index;
                    recycle_wr  = recycle_wr + SLOT_W'(1);
                    recycle_cnt = recycle_cnt + CNT_W'(1);
                end
            end
            CMD_READ: begin
                if ({1'b0, c.slot_index} >= watermark) begin
                    r.status = ST_BAD;
                end else if (slot_busy[c.slot_index]) begin
                    r.read_value = slot_value[c.slot_index];
                end
            end
            default: begin
            end
        endcase
        r.table_size = watermark;
        r.live_count = watermark - recycle_cnt;
        return r;
    endfunction

    task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [VAL_W-1:0] value);
        table_cmd_t c;
        c.cmd         = cmd;
        c.slot_index  = slot;
        c.entry_value = value;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // slot below the watermark (any slot while the watermark is zero), occupied if one turns up in a few tries
    function automatic logic [SLOT_W-1:0] pick_slot();
        logic [SLOT_W-1:0] s;
        s = SLOT_W'($urandom_range(0, CAP - 1));
        if (watermark == 0)
            return s;
        for (int i = 0; i < 8; i++) begin
            s = SLOT_W'($urandom_range(0, watermark - 1));
            if (slot_busy[s])
                return s;
        end
        return s;
    endfunction

    task automatic gen_chunk(chunk_kind_t kind, int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            case (kind)
                CHUNK_FILL: r = (r < 85) ? 0 : 70;
                CHUNK_DRAIN: r = (r < 75) ? 50 : r;
                CHUNK_READS: r = (r < 80) ? 80 : r;
                CHUNK_NOISE: r = 95;
                default: begin
                end
            endcase
            if (r < 40)
                push_cmd(CMD_ADD, SLOT_W'($urandom_range(0, CAP - 1)), $urandom);
            else if (r < 65)
                push_cmd(CMD_REMOVE, pick_slot(), $urandom);
            else if (r < 92)
                push_cmd(CMD_READ, pick_slot(), $urandom);
            else if (r < 98)
                push_cmd(CMD_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, CAP - 1)),
                         $urandom);
            else
                push_cmd(CMD_UNUSED, SLOT_W'($urandom_range(0, CAP - 1)), $urandom);
        end
    endtask

    task automatic wait_backlog_empty();
        while (cmd_backlog.size() != 0)
            @(posedge aclk);
    endtask

    // stream driver
    always @(posedge aclk) begin
        table_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                c.cmd         = s_tdata[1:0];
                c.slot_index  = s_tdata[7:2];
                c.entry_value = s_tdata[39:8];
                replies_due.push_back(table_apply(c));
                cmds_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    c = cmd_backlog.pop_front();
                    s_tdata  <= {c.entry_value, c.slot_index, c.cmd};
                    s_tvalid <= 1'b1;
                    tx_gap   <= tx_no_gaps ? 0 : $urandom_range(0, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor
    always @(posedge aclk) begin
        table_reply_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("reply transfer with no command outstanding: %h", m_tdata);
                    fail_cnt++;
                end else begin
                    e = replies_due.pop_front();
                    if (m_tdata[5:0] !== e.given_slot) begin
                        $error("given_slot expected %0d actual %0d", e.given_slot, m_tdata[5:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[37:6] !== e.read_value) begin
                        $error("read_value expected %h actual %h", e.read_value, m_tdata[37:6]);
                        fail_cnt++;
                    end
                    if (m_tdata[39:38] !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_tdata[39:38]);
                        fail_cnt++;
                    end
                    if (m_tdata[46:40] !== e.table_size) begin
                        $error("table_size expected %0d actual %0d", e.table_size,
                               m_tdata[46:40]);
                        fail_cnt++;
                    end
                    if (m_tdata[53:47] !== e.live_count) begin
                        $error("live_count expected %0d actual %0d", e.live_count,
                               m_tdata[53:47]);
                        fail_cnt++;
                    end
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                if (rx_no_stall || $urandom_range(0, 8) == 0) begin
                    m_tready <= 1'b1;
                    rx_stall <= 0;
                end else begin
                    m_tready <= 1'b0;
                    rx_stall <= $urandom_range(0, 7);
                end
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        while (cmds_accepted < 150)
            @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYC) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int perm [CAP];
        int j;
        int tmp;
        int kind;
        for (int i = 0; i < CAP; i++) begin
            slot_value[i]   = '0;
            slot_busy[i]    = 1'b0;
            recycle_fifo[i] = '0;
        end
        recycle_rd  = '0;
        recycle_wr  = '0;
        recycle_cnt = '0;
        watermark   = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // corner cases: extreme values, bad and free slots, reuse, unused cmd
        push_cmd(CMD_ADD, 6'd63, 32'h0000_0000);
        push_cmd(CMD_ADD, 6'd0, 32'hFFFF_FFFF);
        push_cmd(CMD_ADD, 6'd21, 32'hA5A5_A5A5);
        push_cmd(CMD_READ, 6'd0, 32'hFFFF_FFFF);
        push_cmd(CMD_READ, 6'd1, 32'h0);
        push_cmd(CMD_READ, 6'd2, 32'h0);
        push_cmd(CMD_READ, 6'd3, 32'h0);
        push_cmd(CMD_READ, 6'd63, 32'h0);
        push_cmd(CMD_REMOVE, 6'd1, 32'h0);
        push_cmd(CMD_REMOVE, 6'd1, 32'h0);
        push_cmd(CMD_READ, 6'd1, 32'h0);
        push_cmd(CMD_REMOVE, 6'd63, 32'hFFFF_FFFF);
        push_cmd(CMD_ADD, 6'd0, 32'h1234_5678);
        push_cmd(CMD_READ, 6'd1, 32'h0);
        push_cmd(CMD_REMOVE, 6'd0, 32'h0);
        push_cmd(CMD_REMOVE, 6'd2, 32'h0);
        push_cmd(CMD_ADD, 6'd0, 32'h5A5A_5A5A);
        push_cmd(CMD_ADD, 6'd0, 32'h8000_0001);
        push_cmd(CMD_ADD, 6'd0, 32'h7FFF_FFFE);
        push_cmd(CMD_READ, 6'd0, 32'h0);
        push_cmd(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);
        push_cmd(CMD_UNUSED, 6'd0, 32'h0);

        // run the table into full, then free every slot in random order
        tx_no_gaps = 1'b1;
        for (int i = 0; i < CAP + 6; i++)
            push_cmd(CMD_ADD, SLOT_W'($urandom_range(0, CAP - 1)), $urandom);
        wait_backlog_empty();
        tx_no_gaps = 1'b0;
        for (int i = 0; i < CAP; i++)
            perm[i] = i;
        for (int i = CAP - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < CAP; i++)
            push_cmd(CMD_REMOVE, SLOT_W'(perm[i]), $urandom);
        push_cmd(CMD_REMOVE, SLOT_W'(perm[0]), $urandom);
        push_cmd(CMD_ADD, 6'd0, $urandom);

        while (cmds_queued < NUM_ITEMS) begin
            wait_backlog_empty();
            tx_no_gaps  = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 4)
                gen_chunk(CHUNK_MIXED, $urandom_range(8, 30));
            else if (kind < 6)
                gen_chunk(CHUNK_FILL, $urandom_range(8, 30));
            else if (kind < 8)
                gen_chunk(CHUNK_DRAIN, $urandom_range(8, 30));
            else if (kind < 9)
                gen_chunk(CHUNK_READS, $urandom_range(8, 30));
            else
                gen_chunk(CHUNK_NOISE, $urandom_range(8, 30));
        end

        // every queued command transferred, then every reply checked
        wait_backlog_empty();
        while (cmds_accepted < cmds_queued)
            @(posedge aclk);
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/htfsr_pkg.sv
rtl/htfsr_free_fifo.sv
rtl/htfsr_entry_mem.sv
rtl/handle_table_free_slot_reuse_unit.sv
verif/handle_table_free_slot_reuse_unit_tb.sv
